### design/mrrx_pkg.sv
// shared types, constants and the crc byte update for the modbus rtu request receiver
package mrrx_pkg;

   // frame store size and derived limits
   localparam int FRAME_BYTES_DEFAULT = 64;
   localparam int CNT_W               = 10;  // wide enough for 6 + 2 * 255
   localparam int QDEPTH              = 2;

   // register reset values
   localparam logic [7:0]  SLAVE_ID_RESET    = 8'd1;
   localparam logic [9:0]  TICK_PERIOD_RESET = 10'd100;
   localparam logic [15:0] GAP_LIMIT_RESET   = 16'd911;
   localparam logic [15:0] IDLE_RESET_RESET  = 16'd1000;

   // register indexes on the csr port
   localparam logic [1:0] CSR_SLAVE_ID    = 2'd0;
   localparam logic [1:0] CSR_TICK_PERIOD = 2'd1;
   localparam logic [1:0] CSR_GAP_LIMIT   = 2'd2;
   localparam logic [1:0] CSR_IDLE_RESET  = 2'd3;

   // protocol constants
   localparam logic [7:0]  BROADCAST_ID      = 8'd255;
   localparam logic [7:0]  FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0]  FC_READ_INPUT     = 8'd4;
   localparam logic [7:0]  FC_WRITE_MULTIPLE = 8'd16;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;

   // byte positions within a frame
   localparam int POS_START_HI   = 2;
   localparam int POS_START_LO   = 3;
   localparam int POS_QTY_HI     = 4;
   localparam int POS_QTY_LO     = 5;
   localparam int POS_BYTE_COUNT = 6;
   localparam int POS_FIRST_DATA = 7;

   // input opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE, PH_FUN, PH_ADDNUM, PH_BYTECNT, PH_DATA, PH_CHKLO, PH_CHKHI, PH_WAIT
   } phase_type;

   typedef enum logic [1:0] {
      F_TAKE, F_MUL, F_EXEC
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE, B_HEAD, B_READ, B_DATA
   } back_state_type;

   typedef struct packed {
      logic [7:0]  slave_id;
      logic [9:0]  tick_period_us;
      logic [15:0] gap_limit_us;
      logic [15:0] idle_reset_ticks;
   } cfg_type;

   // header of one finished frame, as queued for the back end
   typedef struct packed {
      logic        frame_status;
      logic        is_broadcast;
      logic [4:0]  function_code;
      logic [15:0] start_address;
      logic [15:0] quantity;
      logic [7:0]  byte_count;
      logic        has_data;
   } hdr_type;

   // back-pressure seen by the front end
   typedef struct packed {
      logic q_empty;
      logic q_full;
      logic back_busy;
   } flow_type;

   // crc-16/modbus over one byte, reflected
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### design/mrrx_ram.sv
// generic single write port ram with registered read
module mrrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mrrx_front.sv
// front end: takes bytes and ticks, runs the receive phases, fills the store, queues headers
module mrrx_front #(
   parameter int FRAME_BYTES = 64,
   localparam int IDX_W      = $clog2(FRAME_BYTES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [7:0]         req_rx_byte,
   input  mrrx_pkg::cfg_type  cfg,
   input  mrrx_pkg::flow_type flow,
   output logic               push,
   output mrrx_pkg::hdr_type  push_hdr,
   output logic [IDX_W-1:0]   push_last,
   output logic               ram_we,
   output logic [IDX_W-1:0]   ram_waddr,
   output logic [7:0]         ram_wdata
);
   import mrrx_pkg::*;

   localparam logic [CNT_W-1:0] BC_MAX   = CNT_W'(FRAME_BYTES - 6);
   localparam logic [CNT_W-1:0] LAST_MAX = CNT_W'(FRAME_BYTES - 3);

   front_state_type state_ff, state_in;
   phase_type       phase_ff, phase_in;

   logic             op_ff, op_in;
   logic [7:0]       byte_ff, byte_in;
   logic [25:0]      silence_us_ff, silence_us_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [15:0]      silent_ff, silent_in;
   logic             pending_ff, pending_in;
   logic [15:0]      crc_ff, crc_in;
   logic             bcast_ff, bcast_in;
   logic [4:0]       fc_ff, fc_in;
   logic [15:0]      start_ff, start_in;
   logic [15:0]      qty_ff, qty_in;
   logic [7:0]       bc_ff, bc_in;
   logic [7:0]       got_lo_ff, got_lo_in;
   logic [7:0]       got_hi_ff, got_hi_in;

   logic             accept;
   logic [IDX_W-1:0] idx_next;
   logic [CNT_W-1:0] data_end;
   logic [CNT_W-1:0] data_end_min;
   logic [15:0]      crc_next;
   logic             is_write;
   logic             emit;

   assign accept   = req_valid && req_ready;
   assign idx_next = idx_ff + 1'b1;
   assign crc_next = crc_byte(crc_ff, byte_ff);
   assign is_write = (fc_ff == FC_WRITE_MULTIPLE[4:0]);
   assign data_end = CNT_W'(POS_BYTE_COUNT) + {1'b0, qty_ff[7:0], 1'b0};
   assign data_end_min = (data_end < CNT_W'(POS_FIRST_DATA)) ? CNT_W'(POS_FIRST_DATA)
                                                               : data_end;
   assign emit     = pending_ff && (silence_us_ff > 26'(cfg.gap_limit_us));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_TAKE:  if (accept) state_in = F_MUL;
         F_MUL:   state_in = F_EXEC;
         F_EXEC:  state_in = F_TAKE;
         default: state_in = F_TAKE;
      endcase
   end

   // ready: a tick needs room in the queue, a byte needs the store free of readers
   always_comb begin
      req_ready = 1'b0;
      case (state_ff)
         F_TAKE: begin
            if (req_opcode == OP_TICK) begin
               req_ready = !flow.q_full;
            end else begin
               req_ready = flow.q_empty && !flow.back_busy;
            end
         end
         default: req_ready = 1'b0;
      endcase
   end

   // item execution
   always_comb begin
      op_in         = op_ff;
      byte_in       = byte_ff;
      silence_us_in = silence_us_ff;
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      silent_in     = silent_ff;
      pending_in    = pending_ff;
      crc_in        = crc_ff;
      bcast_in      = bcast_ff;
      fc_in         = fc_ff;
      start_in      = start_ff;
      qty_in        = qty_ff;
      bc_in         = bc_ff;
      got_lo_in     = got_lo_ff;
      got_hi_in     = got_hi_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_next;
      ram_wdata     = byte_ff;
      push          = 1'b0;

      if (accept) begin
         op_in   = req_opcode;
         byte_in = req_rx_byte;
      end

      // silence in microseconds, registered ahead of the compare
      if (state_ff == F_MUL) begin
         silence_us_in = silent_ff * cfg.tick_period_us;
      end

      if (state_ff == F_EXEC) begin
         if (op_ff == OP_TICK) begin
            if (emit) begin
               push       = 1'b1;
               pending_in = 1'b0;
               phase_in   = PH_IDLE;
            end
            if ({1'b0, silent_ff} + 17'd1 > {1'b0, cfg.idle_reset_ticks}) begin
               silent_in  = '0;
               phase_in   = PH_IDLE;
               pending_in = 1'b0;
            end else begin
               silent_in = silent_ff + 16'd1;
            end
         end else begin
            silent_in = '0;
            case (phase_ff)
               PH_IDLE: begin
                  if (byte_ff == cfg.slave_id || byte_ff == BROADCAST_ID) begin
                     idx_in    = '0;
                     ram_we    = 1'b1;
                     ram_waddr = '0;
                     bcast_in  = (byte_ff == BROADCAST_ID);
                     crc_in    = crc_byte(CRC_INIT, byte_ff);
                     phase_in  = PH_FUN;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_FUN: begin
                  if (byte_ff inside {FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_MULTIPLE}) begin
                     idx_in   = idx_next;
                     ram_we   = 1'b1;
                     fc_in    = byte_ff[4:0];
                     crc_in   = crc_next;
                     phase_in = PH_ADDNUM;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_ADDNUM: begin
                  idx_in = idx_next;
                  ram_we = 1'b1;
                  crc_in = crc_next;
                  if (idx_next == IDX_W'(POS_START_HI)) start_in[15:8] = byte_ff;
                  if (idx_next == IDX_W'(POS_START_LO)) start_in[7:0]  = byte_ff;
                  if (idx_next == IDX_W'(POS_QTY_HI))   qty_in[15:8]   = byte_ff;
                  if (idx_next == IDX_W'(POS_QTY_LO))   qty_in[7:0]    = byte_ff;
                  if (idx_next >= IDX_W'(POS_QTY_LO)) begin
                     if (is_write) begin
                        phase_in = PH_BYTECNT;
                     end else begin
                        last_in  = IDX_W'(POS_QTY_LO);
                        phase_in = PH_CHKLO;
                     end
                  end
               end
               PH_BYTECNT: begin
                  if ({2'b00, byte_ff} > BC_MAX || data_end_min > LAST_MAX) begin
                     phase_in = PH_WAIT;
                  end else begin
                     idx_in   = idx_next;
                     ram_we   = 1'b1;
                     bc_in    = byte_ff;
                     crc_in   = crc_next;
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  idx_in = idx_next;
                  ram_we = 1'b1;
                  crc_in = crc_next;
                  if (CNT_W'(idx_next) >= data_end || CNT_W'(idx_next) >= LAST_MAX) begin
                     last_in  = idx_next;
                     phase_in = PH_CHKLO;
                  end
               end
               PH_CHKLO: begin
                  idx_in    = idx_next;
                  ram_we    = 1'b1;
                  got_lo_in = byte_ff;
                  phase_in  = PH_CHKHI;
               end
               PH_CHKHI: begin
                  idx_in     = idx_next;
                  ram_we     = 1'b1;
                  got_hi_in  = byte_ff;
                  pending_in = 1'b1;
                  phase_in   = PH_WAIT;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // header as handed to the queue
   always_comb begin
      push_hdr.frame_status  = ({got_hi_ff, got_lo_ff} != crc_ff);
      push_hdr.is_broadcast  = bcast_ff;
      push_hdr.function_code = fc_ff;
      push_hdr.start_address = start_ff;
      push_hdr.quantity      = qty_ff;
      push_hdr.byte_count    = is_write ? bc_ff : 8'd0;
      push_hdr.has_data      = is_write && (last_ff > IDX_W'(POS_BYTE_COUNT));
      push_last              = last_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_TAKE;
         phase_ff   <= PH_IDLE;
         idx_ff     <= '0;
         last_ff    <= '0;
         silent_ff  <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         last_ff    <= last_in;
         silent_ff  <= silent_in;
         pending_ff <= pending_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      byte_ff       <= byte_in;
      silence_us_ff <= silence_us_in;
      crc_ff        <= crc_in;
      bcast_ff      <= bcast_in;
      fc_ff         <= fc_in;
      start_ff      <= start_in;
      qty_ff        <= qty_in;
      bc_ff         <= bc_in;
      got_lo_ff     <= got_lo_in;
      got_hi_ff     <= got_hi_in;
   end

endmodule

### design/mrrx_queue.sv
// short queue of frame headers between front and back end
module mrrx_queue #(
   parameter int FRAME_BYTES = 64,
   localparam int IDX_W      = $clog2(FRAME_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mrrx_pkg::hdr_type push_hdr,
   input  logic [IDX_W-1:0]  push_last,
   input  logic              pop,
   output mrrx_pkg::hdr_type pop_hdr,
   output logic [IDX_W-1:0]  pop_last,
   output logic              empty,
   output logic              full
);
   import mrrx_pkg::*;

   localparam int PTR_W = $clog2(QDEPTH);

   hdr_type          hdr_ff  [QDEPTH];
   logic [IDX_W-1:0] last_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (PTR_W + 1)'(QDEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_hdr  = hdr_ff[rd_ptr_ff];
   assign pop_last = last_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         hdr_ff[wr_ptr_ff]  <= push_hdr;
         last_ff[wr_ptr_ff] <= push_last;
      end
   end

endmodule

### design/mrrx_back.sv
// back end: sends the header, then walks the store for the write data bytes
module mrrx_back #(
   parameter int FRAME_BYTES = 64,
   localparam int IDX_W      = $clog2(FRAME_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  mrrx_pkg::hdr_type q_hdr,
   input  logic [IDX_W-1:0]  q_last,
   output logic              pop,
   output logic              busy,
   output logic              ram_re,
   output logic [IDX_W-1:0]  ram_raddr,
   input  logic [7:0]        ram_rdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_item_kind,
   output logic              rsp_frame_status,
   output logic              rsp_is_broadcast,
   output logic [4:0]        rsp_function_code,
   output logic [15:0]       rsp_start_address,
   output logic [15:0]       rsp_quantity,
   output logic [7:0]        rsp_byte_count,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_last
);
   import mrrx_pkg::*;

   back_state_type   state_ff, state_in;
   hdr_type          hdr_ff, hdr_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             transfer;
   logic             at_end;

   assign transfer = rsp_valid && rsp_ready;
   assign at_end   = (addr_ff == last_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (!q_empty) state_in = B_HEAD;
         B_HEAD: if (transfer) state_in = hdr_ff.has_data ? B_READ : B_IDLE;
         B_READ: state_in = B_DATA;
         B_DATA: if (transfer) state_in = at_end ? B_IDLE : B_READ;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs and store reads
   always_comb begin
      hdr_in    = hdr_ff;
      last_in   = last_ff;
      addr_in   = addr_ff;
      pop       = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = addr_ff;
      busy      = (state_ff != B_IDLE);

      rsp_valid         = 1'b0;
      rsp_item_kind     = 1'b0;
      rsp_frame_status  = 1'b0;
      rsp_is_broadcast  = 1'b0;
      rsp_function_code = '0;
      rsp_start_address = '0;
      rsp_quantity      = '0;
      rsp_byte_count    = '0;
      rsp_data_byte     = '0;
      rsp_last          = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               hdr_in  = q_hdr;
               last_in = q_last;
            end
         end
         B_HEAD: begin
            rsp_valid         = 1'b1;
            rsp_frame_status  = hdr_ff.frame_status;
            rsp_is_broadcast  = hdr_ff.is_broadcast;
            rsp_function_code = hdr_ff.function_code;
            rsp_start_address = hdr_ff.start_address;
            rsp_quantity      = hdr_ff.quantity;
            rsp_byte_count    = hdr_ff.byte_count;
            rsp_last          = !hdr_ff.has_data;
            if (transfer && hdr_ff.has_data) begin
               ram_re    = 1'b1;
               ram_raddr = IDX_W'(POS_FIRST_DATA);
               addr_in   = IDX_W'(POS_FIRST_DATA);
            end
         end
         B_READ: begin
            rsp_valid = 1'b0;
         end
         B_DATA: begin
            rsp_valid     = 1'b1;
            rsp_item_kind = 1'b1;
            rsp_data_byte = ram_rdata;
            rsp_last      = at_end;
            if (transfer && !at_end) begin
               ram_re    = 1'b1;
               ram_raddr = addr_ff + 1'b1;
               addr_in   = addr_ff + 1'b1;
            end
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff  <= hdr_in;
      last_ff <= last_in;
      addr_ff <= addr_in;
   end

endmodule

### design/modbus_rtu_request_receiver.sv
// top level of the modbus rtu request receiver: registers, front, queue, back and frame store
//
//  channel  ports        direction  moves
//  req      req_*        in         one tick (opcode 0) or one received byte (opcode 1)
//  rsp      rsp_*        out        frame header, then the write data bytes of the frame
//  csr      csr_*        in         register write, index and data, taken at once
//
// The front end handles a byte or tick in order: accept, silence multiply, phase update.
// A header is queued when its tick is executed and is sent once the back end pops it; each
// data byte then needs a store read (B_READ) and a transfer on rsp (B_DATA), which may stall.
// Bytes are held off while a frame is queued or draining, since they share the store;
// ticks only wait for queue space. Reset is synchronous and needs no clearing pass.
module modbus_rtu_request_receiver #(
   parameter int FRAME_BYTES = mrrx_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_item_kind,
   output logic        rsp_frame_status,
   output logic        rsp_is_broadcast,
   output logic [4:0]  rsp_function_code,
   output logic [15:0] rsp_start_address,
   output logic [15:0] rsp_quantity,
   output logic [7:0]  rsp_byte_count,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import mrrx_pkg::*;

   localparam int IDX_W = $clog2(FRAME_BYTES);

   cfg_type          cfg_ff, cfg_in;
   flow_type         flow;
   logic             push;
   hdr_type          push_hdr;
   logic [IDX_W-1:0] push_last;
   logic             pop;
   hdr_type          pop_hdr;
   logic [IDX_W-1:0] pop_last;
   logic             q_empty;
   logic             q_full;
   logic             back_busy;
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic             ram_re;
   logic [IDX_W-1:0] ram_raddr;
   logic [7:0]       ram_rdata;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SLAVE_ID:    cfg_in.slave_id         = csr_wdata[7:0];
            CSR_TICK_PERIOD: cfg_in.tick_period_us   = csr_wdata[9:0];
            CSR_GAP_LIMIT:   cfg_in.gap_limit_us     = csr_wdata;
            CSR_IDLE_RESET:  cfg_in.idle_reset_ticks = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_id         <= SLAVE_ID_RESET;
         cfg_ff.tick_period_us   <= TICK_PERIOD_RESET;
         cfg_ff.gap_limit_us     <= GAP_LIMIT_RESET;
         cfg_ff.idle_reset_ticks <= IDLE_RESET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // back-pressure towards the front end
   assign flow.q_empty   = q_empty;
   assign flow.q_full    = q_full;
   assign flow.back_busy = back_busy;

   mrrx_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_rx_byte (req_rx_byte),
      .cfg         (cfg_ff),
      .flow        (flow),
      .push        (push),
      .push_hdr    (push_hdr),
      .push_last   (push_last),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata)
   );

   mrrx_queue #(.FRAME_BYTES(FRAME_BYTES)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_hdr  (push_hdr),
      .push_last (push_last),
      .pop       (pop),
      .pop_hdr   (pop_hdr),
      .pop_last  (pop_last),
      .empty     (q_empty),
      .full      (q_full)
   );

   mrrx_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mrrx_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_hdr             (pop_hdr),
      .q_last            (pop_last),
      .pop               (pop),
      .busy              (back_busy),
      .ram_re            (ram_re),
      .ram_raddr         (ram_raddr),
      .ram_rdata         (ram_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_is_broadcast  (rsp_is_broadcast),
      .rsp_function_code (rsp_function_code),
      .rsp_start_address (rsp_start_address),
      .rsp_quantity      (rsp_quantity),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last          (rsp_last)
   );

   // a header is never offered to a full queue
   assert property (@(posedge clock) disable iff (reset) !(push && q_full))
      else $error("header pushed into a full queue");

   // the store is never written while the back end may be reading it
   assert property (@(posedge clock) disable iff (reset) !(ram_we && (back_busy || !q_empty)))
      else $error("frame store written during a drain");

   // the back end is idle right after the final transfer of a run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> !back_busy)
      else $error("back end still busy after the last transfer");

endmodule

### bench/tb_top.sv
// self-checking testbench for the modbus rtu request receiver
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mrrx_pkg::*;

   localparam int BUF_BYTES    = FRAME_BYTES_DEFAULT;
   localparam int SILENCE_CAP  = 80;
   localparam int PRINT_CAP    = 100;

   // one result as it should leave the rsp channel
   typedef struct packed {
      logic        kind;
      logic        status;
      logic        bcast;
      logic [4:0]  fcode;
      logic [15:0] start;
      logic [15:0] qty;
      logic [7:0]  bcount;
      logic [7:0]  data;
      logic        last;
   } reply_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = OP_TICK;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_item_kind;
   logic        rsp_frame_status;
   logic        rsp_is_broadcast;
   logic [4:0]  rsp_function_code;
   logic [15:0] rsp_start_address;
   logic [15:0] rsp_quantity;
   logic [7:0]  rsp_byte_count;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_SLAVE_ID;
   logic [15:0] csr_wdata = 16'h0000;

   // results still owed by the block, oldest first
   reply_t replies_due[$];
   int     fail_count = 0;
   int     items_sent = 0;

   // sender burst shaping and receiver hold-off
   bit     gaps_on = 1'b1;
   int     burst_left = 0;
   int     rsp_hold_cycles = 0;
   int     stall_mode = 0;
   int     mode_left = 0;

   // register copies
   logic [7:0]  cfg_slave;
   logic [9:0]  cfg_tick;
   logic [15:0] cfg_gap;
   logic [15:0] cfg_idle;

   // receiver state copies
   phase_type   mdl_phase;
   int unsigned mdl_pos;
   logic [7:0]  mdl_frame [BUF_BYTES];
   int unsigned mdl_body_end;
   logic [15:0] mdl_quiet;
   bit          mdl_held;

   modbus_rtu_request_receiver i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_is_broadcast  (rsp_is_broadcast),
      .rsp_function_code (rsp_function_code),
      .rsp_start_address (rsp_start_address),
      .rsp_quantity      (rsp_quantity),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void model_reset();
      cfg_slave    = SLAVE_ID_RESET;
      cfg_tick     = TICK_PERIOD_RESET;
      cfg_gap      = GAP_LIMIT_RESET;
      cfg_idle     = IDLE_RESET_RESET;
      mdl_phase    = PH_IDLE;
      mdl_pos      = 0;
      mdl_body_end = 0;
      mdl_quiet    = '0;
      mdl_held     = 1'b0;
      foreach (mdl_frame[i]) mdl_frame[i] = 8'h00;
   endfunction

   function automatic logic [7:0] frame_at(input int unsigned i);
      return (i < BUF_BYTES) ? mdl_frame[i] : 8'h00;
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      mdl_pos++;
      if (mdl_pos < BUF_BYTES) mdl_frame[mdl_pos] = b;
   endfunction

   // crc-16/modbus, reflected, over a whole byte list
   function automatic logic [15:0] crc16_modbus(input logic [7:0] bytes[$]);
      logic [15:0] c;
      c = CRC_INIT;
      foreach (bytes[i]) begin
         c ^= {8'h00, bytes[i]};
         repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // header then the stored write data of the held frame
   function automatic void queue_frame_replies();
      logic [7:0]  body[$];
      logic [7:0]  fc;
      logic [15:0] got;
      int unsigned ndata;
      reply_t      r;
      for (int unsigned i = 0; i <= mdl_body_end; i++) body.push_back(frame_at(i));
      fc    = frame_at(1);
      got   = {frame_at(mdl_body_end + 2), frame_at(mdl_body_end + 1)};
      ndata = (fc == FC_WRITE_MULTIPLE && mdl_body_end > 6) ? mdl_body_end - 6 : 0;
      r        = '0;
      r.status = (got != crc16_modbus(body));
      r.bcast  = (frame_at(0) == BROADCAST_ID);
      r.fcode  = fc[4:0];
      r.start  = {frame_at(POS_START_HI), frame_at(POS_START_LO)};
      r.qty    = {frame_at(POS_QTY_HI), frame_at(POS_QTY_LO)};
      r.bcount = (fc == FC_WRITE_MULTIPLE) ? frame_at(POS_BYTE_COUNT) : 8'h00;
      r.last   = (ndata == 0);
      replies_due.push_back(r);
      for (int unsigned i = 0; i < ndata; i++) begin
         r      = '0;
         r.kind = 1'b1;
         r.data = frame_at(POS_FIRST_DATA + i);
         r.last = (i + 1 == ndata);
         replies_due.push_back(r);
      end
   endfunction

   // one received byte through the frame parser
   function automatic void model_byte(input logic [7:0] b);
      int unsigned body_lim;
      mdl_quiet = '0;
      case (mdl_phase)
         PH_IDLE: begin
            if (b == cfg_slave || b == BROADCAST_ID) begin
               mdl_pos      = 0;
               mdl_frame[0] = b;
               mdl_phase    = PH_FUN;
            end else begin
               mdl_phase = PH_WAIT;
            end
         end
         PH_FUN: begin
            if (b == FC_READ_HOLDING || b == FC_READ_INPUT || b == FC_WRITE_MULTIPLE) begin
               append_byte(b);
               mdl_phase = PH_ADDNUM;
            end else begin
               mdl_phase = PH_WAIT;
            end
         end
         PH_ADDNUM: begin
            append_byte(b);
            if (mdl_pos >= POS_QTY_LO) begin
               if (frame_at(1) == FC_WRITE_MULTIPLE) begin
                  mdl_phase = PH_BYTECNT;
               end else begin
                  mdl_body_end = POS_QTY_LO;
                  mdl_phase    = PH_CHKLO;
               end
            end
         end
         PH_BYTECNT: begin
            body_lim = 6 + 2 * frame_at(POS_QTY_LO);
            if (body_lim < 7) body_lim = 7;
            // byte count too big, or the write would not fit the store
            if (b > BUF_BYTES - 6 || body_lim > BUF_BYTES - 3) begin
               mdl_phase = PH_WAIT;
            end else begin
               append_byte(b);
               mdl_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            append_byte(b);
            if (mdl_pos >= 6 + 2 * frame_at(POS_QTY_LO) || mdl_pos >= BUF_BYTES - 3) begin
               mdl_body_end = mdl_pos;
               mdl_phase    = PH_CHKLO;
            end
         end
         PH_CHKLO: begin
            append_byte(b);
            mdl_phase = PH_CHKHI;
         end
         PH_CHKHI: begin
            append_byte(b);
            mdl_held  = 1'b1;
            mdl_phase = PH_WAIT;
         end
         default: ;
      endcase
   endfunction

   // one timer tick: end-of-frame check, then silence count and idle reset
   function automatic void model_tick();
      if (mdl_held && 32'(mdl_quiet) * 32'(cfg_tick) > 32'(cfg_gap)) begin
         queue_frame_replies();
         mdl_held  = 1'b0;
         mdl_phase = PH_IDLE;
      end
      if (32'(mdl_quiet) + 1 > 32'(cfg_idle)) begin
         mdl_quiet = '0;
         mdl_phase = PH_IDLE;
         mdl_held  = 1'b0;
      end else begin
         mdl_quiet = mdl_quiet + 16'd1;
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic log_mismatch(input string msg);
      fail_count++;
      // keep the log short on a badly broken block
      if (fail_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // compare each rsp transfer with the oldest owed result
   always @(posedge clock) begin
      reply_t due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            log_mismatch("result with nothing owed");
         end else begin
            due = replies_due.pop_front();
            check_field("item_kind", rsp_item_kind, due.kind);
            check_field("frame_status", rsp_frame_status, due.status);
            check_field("is_broadcast", rsp_is_broadcast, due.bcast);
            check_field("function_code", rsp_function_code, due.fcode);
            check_field("start_address", rsp_start_address, due.start);
            check_field("quantity", rsp_quantity, due.qty);
            check_field("byte_count", rsp_byte_count, due.bcount);
            check_field("data_byte", rsp_data_byte, due.data);
            check_field("last", rsp_last, due.last);
         end
      end
   end

   // ---------------------------------------------------------------- receiver side

   // long hold-off first, otherwise a stall pattern that changes now and then
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(32, 256);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- sender side

   // one req transfer, valid held until accepted
   task automatic send_item(input logic op, input logic [7:0] value);
      int gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap        = $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // bytes dropped in the wait phase do not count towards the budget
      if (op == OP_TICK || mdl_phase != PH_WAIT) items_sent++;
      if (op == OP_TICK) model_tick();
      else model_byte(value);
   endtask

   // stop offering, let every owed result drain, then a few quiet cycles
   task automatic settle(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SLAVE_ID:    cfg_slave = value[7:0];
         CSR_TICK_PERIOD: cfg_tick  = value[9:0];
         CSR_GAP_LIMIT:   cfg_gap   = value;
         CSR_IDLE_RESET:  cfg_idle  = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] slave, input logic [9:0] period,
                             input logic [15:0] gap, input logic [15:0] idle);
      settle(20);
      write_reg(CSR_SLAVE_ID, {8'h00, slave});
      write_reg(CSR_TICK_PERIOD, {6'h00, period});
      write_reg(CSR_GAP_LIMIT, gap);
      write_reg(CSR_IDLE_RESET, idle);
   endtask

   // ticks until the receiver is back in idle with nothing held, then a few more
   task automatic send_silence(input int extra);
      int n;
      n = 0;
      while ((mdl_phase != PH_IDLE || mdl_held) && n < SILENCE_CAP) begin
         send_item(OP_TICK, 8'($urandom));
         n++;
      end
      repeat (extra) send_item(OP_TICK, 8'($urandom));
   endtask

   // build a request with its crc and send the first cut bytes (all when cut < 0)
   task automatic send_request(input logic [7:0] addr, input logic [7:0] fc,
                               input logic [15:0] start, input logic [15:0] qty,
                               input logic [7:0] bcount, input int ndata,
                               input bit bad_crc, input int cut);
      logic [7:0]  bytes[$];
      logic [15:0] crc;
      int          n;
      bytes = '{addr, fc, start[15:8], start[7:0], qty[15:8], qty[7:0]};
      if (fc == FC_WRITE_MULTIPLE) begin
         bytes.push_back(bcount);
         repeat (ndata) bytes.push_back(8'($urandom));
      end
      crc = crc16_modbus(bytes);
      if (bad_crc) crc ^= 16'($urandom_range(1, 16'hFFFF));
      bytes.push_back(crc[7:0]);
      bytes.push_back(crc[15:8]);
      n = (cut < 0 || cut > bytes.size()) ? bytes.size() : cut;
      for (int i = 0; i < n; i++) send_item(OP_BYTE, bytes[i]);
   endtask

   // mostly well-formed requests with random content, some noise and broken ones
   task automatic send_random_request(input bit allow_bad);
      int          pick;
      int          qlo;
      int          nd;
      int          cut;
      logic [7:0]  addr;
      logic [7:0]  fc;
      logic [7:0]  bcount;
      logic [15:0] start;
      logic [15:0] qty;
      bit          bad_crc;
      if (allow_bad && $urandom_range(0, 99) < 6) begin
         repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom));
         send_silence($urandom_range(0, 2));
         return;
      end
      addr = $urandom_range(0, 1) ? cfg_slave : BROADCAST_ID;
      if (allow_bad && $urandom_range(0, 19) == 0) addr = 8'($urandom);
      case ($urandom_range(0, 2))
         0: fc = FC_READ_HOLDING;
         1: fc = FC_READ_INPUT;
         default: fc = FC_WRITE_MULTIPLE;
      endcase
      if (allow_bad && $urandom_range(0, 19) == 0) fc = 8'($urandom);
      start = 16'($urandom);
      qty   = 16'($urandom);
      // mostly short writes, now and then longer ones up to the longest that fits, rarely too long
      pick = $urandom_range(0, 99);
      if (pick < 70) qlo = $urandom_range(0, 4);
      else if (pick < 97) qlo = $urandom_range(5, 27);
      else qlo = allow_bad ? $urandom_range(28, 255) : 27;
      qty[7:0] = qlo[7:0];
      bcount = $urandom_range(0, BUF_BYTES - 6);
      if (allow_bad && $urandom_range(0, 19) == 0) bcount = $urandom_range(BUF_BYTES - 5, 255);
      nd = (qlo == 0) ? 1 : 2 * qlo;
      if (qlo > 27) nd = 6;
      bad_crc = ($urandom_range(0, 6) == 0);
      cut = (allow_bad && $urandom_range(0, 19) == 0) ? $urandom_range(1, 6) : -1;
      send_request(addr, fc, start, qty, bcount, nd, bad_crc, cut);
      if ($urandom_range(0, 19) == 0) send_item(OP_BYTE, 8'($urandom));
      // a silence too short lets the next request run into a held frame
      if (allow_bad && $urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(0, 1)) send_item(OP_TICK, 8'($urandom));
      end else begin
         send_silence($urandom_range(0, 2));
      end
   endtask

   task automatic run_random(input int budget, input bit allow_bad);
      int stop_at;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) send_random_request(allow_bad);
      send_silence(0);
   endtask

   // ---------------------------------------------------------------- tests

   // bad address, bad function, byte count too big, write too long
   task automatic test_rejected_requests();
      gaps_on = 1'b1;
      set_config(8'd1, 10'd1000, 16'd999, 16'd1);
      send_request(8'h00, FC_READ_HOLDING, 16'h0000, 16'h0001, 8'h00, 0, 1'b0, 1);
      send_silence(0);
      send_request(8'd1, 8'h07, 16'h0000, 16'h0001, 8'h00, 0, 1'b0, 2);
      send_silence(0);
      send_request(8'd1, FC_WRITE_MULTIPLE, 16'h0000, 16'h0001, 8'd59, 2, 1'b0, 7);
      send_silence(0);
      send_request(8'd1, FC_WRITE_MULTIPLE, 16'h0000, 16'h001C, 8'd2, 56, 1'b0, 7);
      send_silence(0);
   endtask

   // field extremes, a byte while a frame is held, broadcast write with bad crc
   task automatic test_accepted_requests();
      send_request(8'd1, FC_READ_HOLDING, 16'hFFFF, 16'h0000, 8'h00, 0, 1'b0, -1);
      send_item(OP_BYTE, 8'hFF);
      send_silence(0);
      send_request(BROADCAST_ID, FC_WRITE_MULTIPLE, 16'h0000, 16'hFF00, 8'd58, 1, 1'b1, -1);
      send_silence(0);
      send_request(8'd1, FC_READ_INPUT, 16'h8000, 16'h7FFF, 8'h00, 0, 1'b0, -1);
      send_silence(0);
   endtask

   task automatic test_reset_values();
      gaps_on = 1'b1;
      set_config(SLAVE_ID_RESET, TICK_PERIOD_RESET, GAP_LIMIT_RESET, IDLE_RESET_RESET);
      run_random(90, 1'b0);
   endtask

   // shortest gap, idle reset out of reach, sender never pauses
   task automatic test_zero_gap();
      gaps_on = 1'b0;
      set_config(8'd0, 10'd1000, 16'd0, 16'd65535);
      run_random(70, 1'b0);
   endtask

   task automatic test_broadcast_only();
      gaps_on = 1'b1;
      set_config(BROADCAST_ID, 10'd1, 16'd3, 16'd5);
      run_random(70, 1'b1);
   endtask

   // receiver holds off while writes keep coming, so the block fills and stalls req
   task automatic test_backpressure();
      settle(20);
      gaps_on = 1'b0;
      rsp_hold_cycles = 400;
      repeat (4) begin
         send_request(BROADCAST_ID, FC_WRITE_MULTIPLE, 16'($urandom), 16'h0004,
                      8'd8, 8, 1'b0, -1);
         send_silence(0);
      end
      settle(0);
   endtask

   task automatic test_random_settings();
      logic [9:0]  period;
      int          gap;
      gaps_on = $urandom_range(0, 1);
      period  = $urandom_range(1, 1000);
      gap     = $urandom_range(0, 4 * period);
      if (gap > 65535) gap = 65535;
      set_config(8'($urandom), period, 16'(gap), 16'($urandom_range(2, 40)));
      run_random(70, 1'b1);
   endtask

   // widest gap limit, reached only after a long silence
   task automatic test_long_gap();
      gaps_on = 1'b1;
      set_config(8'hAA, 10'd1000, 16'd65535, 16'd70);
      run_random(140, 1'b1);
   endtask

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_rejected_requests();
      test_accepted_requests();
      test_reset_values();
      test_zero_gap();
      test_broadcast_only();
      test_backpressure();
      test_random_settings();
      test_long_gap();
      settle(50);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
